// ----- rtl/rsl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ray / spherical light hit block.
// No dependencies.
package rsl_pkg;

  localparam int unsigned CW        = 32;
  localparam int unsigned FB        = 16;
  localparam int unsigned IPW       = 18;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = CFG_IDX_W'(3);

  localparam logic [CW-1:0] RADIUS_SQ_RST = CW'(65536);

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] near_distance;
    logic [IPW-1:0]       inv_pdf;
  } hit_t;

endpackage

// ----- rtl/rsl_ray_if.sv -----
`timescale 1ns / 1ps
// Ray input channel: valid/ready plus one ray.
// Depends on rsl_pkg.
interface rsl_ray_if;
  logic          valid;
  logic          ready;
  rsl_pkg::ray_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/rsl_hit_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready plus hit flag, near root and inverse pdf.
// Depends on rsl_pkg.
interface rsl_hit_if;
  logic          valid;
  logic          ready;
  rsl_pkg::hit_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/rsl_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel: valid/ready, register index and write data.
// Depends on rsl_pkg.
interface rsl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rsl_pkg::CFG_IDX_W-1:0]    idx;
  logic [rsl_pkg::CW-1:0]           wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

// ----- rtl/ray_sphere_light_hit_pdf.sv -----
`timescale 1ns / 1ps
// Ray / spherical light intersection with cone pdf, fully pipelined.
// Depends on rsl_pkg, rsl_ray_if, rsl_hit_if, rsl_cfg_if.
//
// Usage:
//   ray_i  : one ray per transfer (origin and direction, signed Q16.16).
//   res_o  : one result per ray, in order: hit, near root (Q16.16,
//            saturated) and inverse cone pdf 2(1-cos alpha) in Q2.16.
//   cfg_i  : register writes (0..2 center xyz, 3 squared radius), always
//            ready; write only while no ray is in flight.
// Throughput: one ray per cycle unless stalled. Every stage holds one ray;
// the depth is set by the digit-serial square roots (66 and 32 stages) and
// the restoring dividers (31 and 64 stages), one digit per stage.
// Stall: when a result waits on res_o and res_o.ready is low, the whole
// pipeline freezes and ray_i.ready drops; nothing is lost or repeated.
// Reset: pipeline empties, center clears to 0, squared radius to 1.0.
// Misses (negative discriminant, origin on or inside the sphere, zero
// direction) give hit 0 with both other fields 0.
module ray_sphere_light_hit_pdf (
  input  logic             clk_i,
  input  logic             rst_ni,
  rsl_ray_if.sink          ray_i,
  rsl_hit_if.source        res_o,
  rsl_cfg_if.sink          cfg_i
);

  localparam int unsigned CW   = rsl_pkg::CW;
  localparam int unsigned FB   = rsl_pkg::FB;
  localparam int unsigned IPW  = rsl_pkg::IPW;
  localparam int unsigned VW   = CW + 1;
  localparam int unsigned AW   = 2 * CW;
  localparam int unsigned BW   = 2 * CW + 2;
  localparam int unsigned PW   = 2 * CW + 2;
  localparam int unsigned CCW  = PW + 1;
  localparam int unsigned BMW  = 2 * CW + 1;
  localparam int unsigned LH   = CW + 1;
  localparam int unsigned AH   = CW;
  localparam int unsigned CH   = CW + 1;
  localparam int unsigned B2W  = 2 * BMW;
  localparam int unsigned ACW  = AW + PW;
  localparam int unsigned DW   = 4 * CW + 4;
  localparam int unsigned SRN  = DW / 2;
  localparam int unsigned SRW  = SRN + 2;
  localparam int unsigned NW   = BW + 2;
  localparam int unsigned NUMW = 2 * CW + FB + 4;
  localparam int unsigned QB   = CW - 1;
  localparam int unsigned DVW  = AW + QB;
  localparam int unsigned XB   = 2 * CW;
  localparam int unsigned KB   = CW;
  localparam int unsigned KRW  = KB + 2;
  localparam int unsigned PAD  = SRN + 1 + QB - XB - KB;
  localparam int unsigned LAT  = 9 + SRN + QB;

  // ---------------- config ----------------
  logic signed [CW-1:0] center_q [3];
  logic [CW-1:0]        radius_sq_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q[0] <= '0;
      center_q[1] <= '0;
      center_q[2] <= '0;
      radius_sq_q <= rsl_pkg::RADIUS_SQ_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        rsl_pkg::REG_CENTER_X:  center_q[0] <= cfg_i.wdata;
        rsl_pkg::REG_CENTER_Y:  center_q[1] <= cfg_i.wdata;
        rsl_pkg::REG_CENTER_Z:  center_q[2] <= cfg_i.wdata;
        rsl_pkg::REG_RADIUS_SQ: radius_sq_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [LAT-1:0] vld_q;
  logic           adv;
  logic           acc;

  assign adv         = !vld_q[LAT-1] || res_o.ready;
  assign acc         = ray_i.valid && adv;
  assign ray_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], acc};
    end
  end

  // ---------------- s1: offsets ----------------
  logic signed [CW-1:0] org_w [3];
  logic signed [CW-1:0] dir_w [3];
  logic signed [VW-1:0] s1_v_q [3];
  logic signed [CW-1:0] s1_d_q [3];
  logic [CW-1:0]        s1_r_q;

  always_comb begin
    org_w[0] = ray_i.data.origin_x;
    org_w[1] = ray_i.data.origin_y;
    org_w[2] = ray_i.data.origin_z;
    dir_w[0] = ray_i.data.dir_x;
    dir_w[1] = ray_i.data.dir_y;
    dir_w[2] = ray_i.data.dir_z;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s1_v_q[k] <= VW'(org_w[k]) - VW'(center_q[k]);
        s1_d_q[k] <= dir_w[k];
      end
      s1_r_q <= radius_sq_q;
    end
  end

  // ---------------- s2: products ----------------
  logic signed [2*CW-1:0]   dd_w [3];
  logic signed [VW+CW-1:0]  vd_w [3];
  logic signed [2*VW-1:0]   vv_w [3];
  logic [AW-1:0]            s2_dd_q [3];
  logic signed [VW+CW-1:0]  s2_vd_q [3];
  logic [PW-1:0]            s2_vv_q [3];
  logic [CW-1:0]            s2_r_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dd_w[k] = s1_d_q[k] * s1_d_q[k];
      vd_w[k] = s1_v_q[k] * s1_d_q[k];
      vv_w[k] = s1_v_q[k] * s1_v_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_dd_q[k] <= AW'(dd_w[k]);
        s2_vd_q[k] <= vd_w[k];
        s2_vv_q[k] <= PW'(vv_w[k]);
      end
      s2_r_q <= s1_r_q;
    end
  end

  // ---------------- s3: dot products ----------------
  logic [AW-1:0]        s3_a_q;
  logic signed [BW-1:0] s3_b_q;
  logic [PW-1:0]        s3_p_q;
  logic [CW-1:0]        s3_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_a_q <= s2_dd_q[0] + s2_dd_q[1] + s2_dd_q[2];
      s3_b_q <= BW'(s2_vd_q[0]) + BW'(s2_vd_q[1]) + BW'(s2_vd_q[2]);
      s3_p_q <= s2_vv_q[0] + s2_vv_q[1] + s2_vv_q[2];
      s3_r_q <= s2_r_q;
    end
  end

  // ---------------- s4: C = P - r^2 ----------------
  logic [AW-1:0]         s4_a_q;
  logic signed [BW-1:0]  s4_b_q;
  logic [PW-1:0]         s4_p_q;
  logic signed [CCW-1:0] s4_c_q;
  logic                  s4_rz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_a_q  <= s3_a_q;
      s4_b_q  <= s3_b_q;
      s4_p_q  <= s3_p_q;
      s4_c_q  <= $signed({1'b0, s3_p_q}) - $signed(CCW'({s3_r_q, {FB{1'b0}}}));
      s4_rz_q <= (s3_r_q == '0);
    end
  end

  // ---------------- s5: partial products ----------------
  logic [BW-1:0]      bneg_w;
  logic [BMW-1:0]     bm_w;
  logic               cpos_w;
  logic [PW-1:0]      cm_w;
  logic [2*CW-1:0]    s5_bhh_q;
  logic [CW+LH-1:0]   s5_bhl_q;
  logic [2*LH-1:0]    s5_bll_q;
  logic [2*CW:0]      s5_ahch_q;
  logic [2*CW:0]      s5_ahcl_q;
  logic [2*CW:0]      s5_alch_q;
  logic [2*CW:0]      s5_alcl_q;
  logic [AW-1:0]      s5_a_q;
  logic signed [BW-1:0] s5_b_q;
  logic [PW-1:0]      s5_p_q;
  logic [PW-1:0]      s5_c_q;
  logic               s5_az_q;
  logic               s5_cpos_q;
  logic               s5_rz_q;

  always_comb begin
    bneg_w = -s4_b_q;
    bm_w   = s4_b_q[BW-1] ? bneg_w[BMW-1:0] : s4_b_q[BMW-1:0];
    cpos_w = !s4_c_q[CCW-1] && (s4_c_q != '0);
    cm_w   = cpos_w ? s4_c_q[PW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_bhh_q  <= bm_w[BMW-1:LH] * bm_w[BMW-1:LH];
      s5_bhl_q  <= bm_w[BMW-1:LH] * bm_w[LH-1:0];
      s5_bll_q  <= bm_w[LH-1:0] * bm_w[LH-1:0];
      s5_ahch_q <= s4_a_q[AW-1:AH] * cm_w[PW-1:CH];
      s5_ahcl_q <= s4_a_q[AW-1:AH] * cm_w[CH-1:0];
      s5_alch_q <= s4_a_q[AH-1:0] * cm_w[PW-1:CH];
      s5_alcl_q <= s4_a_q[AH-1:0] * cm_w[CH-1:0];
      s5_a_q    <= s4_a_q;
      s5_b_q    <= s4_b_q;
      s5_p_q    <= s4_p_q;
      s5_c_q    <= s4_c_q[PW-1:0];
      s5_az_q   <= (s4_a_q == '0);
      s5_cpos_q <= cpos_w;
      s5_rz_q   <= s4_rz_q;
    end
  end

  // ---------------- s6: B^2 and A*C ----------------
  logic [B2W-1:0]       s6_b2_q;
  logic [ACW-1:0]       s6_ac_q;
  logic [AW-1:0]        s6_a_q;
  logic signed [BW-1:0] s6_b_q;
  logic [PW-1:0]        s6_p_q;
  logic [PW-1:0]        s6_c_q;
  logic                 s6_az_q;
  logic                 s6_cpos_q;
  logic                 s6_rz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_b2_q   <= (B2W'(s5_bhh_q) << (2 * LH)) + (B2W'(s5_bhl_q) << (LH + 1))
                   + B2W'(s5_bll_q);
      s6_ac_q   <= (ACW'(s5_ahch_q) << (AH + CH)) + (ACW'(s5_ahcl_q) << AH)
                   + (ACW'(s5_alch_q) << CH) + ACW'(s5_alcl_q);
      s6_a_q    <= s5_a_q;
      s6_b_q    <= s5_b_q;
      s6_p_q    <= s5_p_q;
      s6_c_q    <= s5_c_q;
      s6_az_q   <= s5_az_q;
      s6_cpos_q <= s5_cpos_q;
      s6_rz_q   <= s5_rz_q;
    end
  end

  // ---------------- s7: discriminant ----------------
  logic signed [DW-1:0] disc_w;
  logic [DW-1:0]        s7_rad_q;
  logic [AW-1:0]        s7_a_q;
  logic signed [BW-1:0] s7_b_q;
  logic [PW-1:0]        s7_p_q;
  logic [PW-1:0]        s7_c_q;
  logic                 s7_miss_q;
  logic                 s7_rz_q;

  assign disc_w = $signed(DW'(s6_b2_q)) - $signed(DW'(s6_ac_q));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_rad_q  <= disc_w[DW-1] ? '0 : disc_w;
      s7_miss_q <= s6_az_q || !s6_cpos_q || disc_w[DW-1];
      s7_a_q    <= s6_a_q;
      s7_b_q    <= s6_b_q;
      s7_p_q    <= s6_p_q;
      s7_c_q    <= s6_c_q;
      s7_rz_q   <= s6_rz_q;
    end
  end

  // ---------------- near root: sqrt(disc), one digit per stage ----------------
  logic [DW-1:0]        sq_rad_q  [1:SRN];
  logic [SRW-1:0]       sq_rem_q  [1:SRN];
  logic [SRN-1:0]       sq_root_q [1:SRN];
  logic [AW-1:0]        sq_a_q    [1:SRN];
  logic signed [BW-1:0] sq_b_q    [1:SRN];
  logic                 sq_miss_q [1:SRN];
  logic                 sq_rz_q   [1:SRN];

  for (genvar j = 1; j <= SRN; j++) begin : g_sq
    logic [DW-1:0]        rad_in;
    logic [SRW-1:0]       rem_in;
    logic [SRN-1:0]       root_in;
    logic [AW-1:0]        a_in;
    logic signed [BW-1:0] b_in;
    logic                 miss_in;
    logic                 rz_in;
    logic [SRW-1:0]       cand;
    logic [SRW-1:0]       trial;
    logic                 ge;

    if (j == 1) begin : g_first
      assign rad_in  = s7_rad_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign a_in    = s7_a_q;
      assign b_in    = s7_b_q;
      assign miss_in = s7_miss_q;
      assign rz_in   = s7_rz_q;
    end else begin : g_next
      assign rad_in  = sq_rad_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
      assign a_in    = sq_a_q[j-1];
      assign b_in    = sq_b_q[j-1];
      assign miss_in = sq_miss_q[j-1];
      assign rz_in   = sq_rz_q[j-1];
    end

    assign cand  = {rem_in[SRW-3:0], rad_in[DW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[j]  <= ge ? (cand - trial) : cand;
        sq_root_q[j] <= {root_in[SRN-2:0], ge};
        sq_rad_q[j]  <= rad_in << 2;
        sq_a_q[j]    <= a_in;
        sq_b_q[j]    <= b_in;
        sq_miss_q[j] <= miss_in;
        sq_rz_q[j]   <= rz_in;
      end
    end
  end

  // ---------------- numerator, rounding bias, saturation test ----------------
  logic signed [NW-1:0] n_w;
  logic [NW-1:0]        nneg_w;
  logic [NW-2:0]        nmag_w;
  logic [NUMW-1:0]      num_w;
  logic [DVW-1:0]       nm_rem_q;
  logic [AW-1:0]        nm_a_q;
  logic                 nm_nneg_q;
  logic                 nm_sat_q;
  logic                 nm_miss_q;
  logic                 nm_rz_q;

  always_comb begin
    n_w    = -NW'(sq_b_q[SRN]) - $signed(NW'(sq_root_q[SRN]));
    nneg_w = -n_w;
    nmag_w = n_w[NW-1] ? nneg_w[NW-2:0] : n_w[NW-2:0];
    num_w  = NUMW'({nmag_w, {FB{1'b0}}}) + NUMW'(sq_a_q[SRN] >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nm_rem_q  <= DVW'(num_w);
      nm_sat_q  <= (DVW'(num_w) >= (DVW'(sq_a_q[SRN]) << QB));
      nm_nneg_q <= n_w[NW-1];
      nm_a_q    <= sq_a_q[SRN];
      nm_miss_q <= sq_miss_q[SRN];
      nm_rz_q   <= sq_rz_q[SRN];
    end
  end

  // ---------------- near root: restoring divide by A ----------------
  logic [DVW-1:0] dv_rem_q  [1:QB];
  logic [QB-1:0]  dv_q_q    [1:QB];
  logic [AW-1:0]  dv_a_q    [1:QB];
  logic           dv_nneg_q [1:QB];
  logic           dv_sat_q  [1:QB];
  logic           dv_miss_q [1:QB];
  logic           dv_rz_q   [1:QB];

  for (genvar j = 1; j <= QB; j++) begin : g_dv
    logic [DVW-1:0] rem_in;
    logic [QB-1:0]  q_in;
    logic [AW-1:0]  a_in;
    logic           nneg_in;
    logic           sat_in;
    logic           miss_in;
    logic           rz_in;
    logic [DVW-1:0] sh;
    logic           ge;

    if (j == 1) begin : g_first
      assign rem_in  = nm_rem_q;
      assign q_in    = '0;
      assign a_in    = nm_a_q;
      assign nneg_in = nm_nneg_q;
      assign sat_in  = nm_sat_q;
      assign miss_in = nm_miss_q;
      assign rz_in   = nm_rz_q;
    end else begin : g_next
      assign rem_in  = dv_rem_q[j-1];
      assign q_in    = dv_q_q[j-1];
      assign a_in    = dv_a_q[j-1];
      assign nneg_in = dv_nneg_q[j-1];
      assign sat_in  = dv_sat_q[j-1];
      assign miss_in = dv_miss_q[j-1];
      assign rz_in   = dv_rz_q[j-1];
    end

    assign sh = DVW'(a_in) << (QB - j);
    assign ge = (rem_in >= sh);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[j]  <= ge ? (rem_in - sh) : rem_in;
        dv_q_q[j]    <= {q_in[QB-2:0], ge};
        dv_a_q[j]    <= a_in;
        dv_nneg_q[j] <= nneg_in;
        dv_sat_q[j]  <= sat_in;
        dv_miss_q[j] <= miss_in;
        dv_rz_q[j]   <= rz_in;
      end
    end
  end

  // ---------------- cone pdf: X = C * 2^64 / P ----------------
  logic [PW-1:0] px_rem_q [1:XB];
  logic [XB-1:0] px_x_q   [1:XB];
  logic [PW-1:0] px_p_q   [1:XB];

  for (genvar j = 1; j <= XB; j++) begin : g_px
    logic [PW-1:0] rem_in;
    logic [XB-1:0] x_in;
    logic [PW-1:0] p_in;
    logic [PW:0]   cand;
    logic [PW:0]   diff;
    logic          ge;

    if (j == 1) begin : g_first
      assign rem_in = s7_c_q;
      assign x_in   = '0;
      assign p_in   = s7_p_q;
    end else begin : g_next
      assign rem_in = px_rem_q[j-1];
      assign x_in   = px_x_q[j-1];
      assign p_in   = px_p_q[j-1];
    end

    assign cand = {rem_in, 1'b0};
    assign ge   = (cand >= {1'b0, p_in});
    assign diff = cand - {1'b0, p_in};

    always_ff @(posedge clk_i) begin
      if (adv) begin
        px_rem_q[j] <= ge ? diff[PW-1:0] : cand[PW-1:0];
        px_x_q[j]   <= {x_in[XB-2:0], ge};
        px_p_q[j]   <= p_in;
      end
    end
  end

  // ---------------- cone pdf: K = sqrt(X) ----------------
  logic [XB-1:0]  ks_rad_q  [1:KB];
  logic [KRW-1:0] ks_rem_q  [1:KB];
  logic [KB-1:0]  ks_root_q [1:KB];

  for (genvar j = 1; j <= KB; j++) begin : g_ks
    logic [XB-1:0]  rad_in;
    logic [KRW-1:0] rem_in;
    logic [KB-1:0]  root_in;
    logic [KRW-1:0] cand;
    logic [KRW-1:0] trial;
    logic           ge;

    if (j == 1) begin : g_first
      assign rad_in  = px_x_q[XB];
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = ks_rad_q[j-1];
      assign rem_in  = ks_rem_q[j-1];
      assign root_in = ks_root_q[j-1];
    end

    assign cand  = {rem_in[KRW-3:0], rad_in[XB-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ks_rem_q[j]  <= ge ? (cand - trial) : cand;
        ks_root_q[j] <= {root_in[KB-2:0], ge};
        ks_rad_q[j]  <= rad_in << 2;
      end
    end
  end

  // align with the near root path
  logic [KB-1:0] pad_k_q [1:PAD];

  for (genvar j = 1; j <= PAD; j++) begin : g_pad
    logic [KB-1:0] k_in;
    if (j == 1) begin : g_first
      assign k_in = ks_root_q[KB];
    end else begin : g_next
      assign k_in = pad_k_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pad_k_q[j] <= k_in;
      end
    end
  end

  // ---------------- output stage ----------------
  logic [KB:0]          kdiff_w;
  logic [KB+1:0]        ipv_w;
  logic signed [CW-1:0] near_w;
  logic [CW-1:0]        qext_w;
  logic                 out_hit_q;
  logic signed [CW-1:0] out_near_q;
  logic [IPW-1:0]       out_inv_q;

  always_comb begin
    kdiff_w = {1'b1, {KB{1'b0}}} - {1'b0, pad_k_q[PAD]};
    ipv_w   = {kdiff_w, 1'b0} + (KB+2)'(1 << (FB - 1));
    qext_w  = CW'(dv_q_q[QB]);
    if (dv_sat_q[QB]) begin
      near_w = dv_nneg_q[QB] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      near_w = dv_nneg_q[QB] ? -qext_w : qext_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hit_q  <= !dv_miss_q[QB];
      out_near_q <= dv_miss_q[QB] ? '0 : near_w;
      out_inv_q  <= (dv_miss_q[QB] || dv_rz_q[QB]) ? '0 : ipv_w[FB +: IPW];
    end
  end

  assign res_o.valid              = vld_q[LAT-1];
  assign res_o.data.hit           = out_hit_q;
  assign res_o.data.near_distance = out_near_q;
  assign res_o.data.inv_pdf       = out_inv_q;

`ifndef ASSERT_OFF
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ray_i.valid && ray_i.ready |=> vld_q[0])
    else $error("accepted ray did not enter first stage");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.data.hit |-> res_o.data.near_distance == '0
      && res_o.data.inv_pdf == '0)
    else $error("miss result carries nonzero fields");

  a_pdf_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.data.inv_pdf <= IPW'(131072))
    else $error("inverse pdf out of range");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[7+SRN+QB] && !dv_sat_q[QB] |-> dv_rem_q[QB] < DVW'(dv_a_q[QB]))
    else $error("near root divider remainder not below divisor");
`endif

endmodule

// ----- test/ray_sphere_light_hit_pdf_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for ray_sphere_light_hit_pdf: directed and random rays,
// predicted in exact wide integer arithmetic. Depends on rsl_pkg and the
// rsl_ray_if, rsl_hit_if and rsl_cfg_if interfaces.
module ray_sphere_light_hit_pdf_tb;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    rsl_pkg::ray_t ray;
    bit            is_miss;
  } ray_row_t;

  localparam int LATENCY     = 106;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ONE         = 65536;

  logic clk_i = 1'b0;
  logic rst_ni;

  rsl_ray_if ray_if ();
  rsl_hit_if hit_if ();
  rsl_cfg_if cfg_if ();

  ray_sphere_light_hit_pdf dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ray_i  (ray_if.sink),
    .res_o  (hit_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [rsl_pkg::CW-1:0] sphere_center [3];
  logic [rsl_pkg::CW-1:0]        sphere_radius_sq;
  rsl_pkg::hit_t                 pending_hits [$];
  int                            mismatches = 0;
  int                            rays_sent = 0;
  int                            hits_seen = 0;
  int                            results_seen = 0;
  int                            cycle_count = 0;
  bit                            quiet = 1'b0;

  function automatic wide_t floor_sqrt(input wide_t a);
    wide_t rem, root, probe;
    rem   = a;
    root  = '0;
    probe = wide_t'(1) << 254;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic rsl_pkg::hit_t sphere_hit(input rsl_pkg::ray_t r);
    wide_t         o [3];
    wide_t         d [3];
    wide_t         v, a, b, p, c, disc, s, n, num, q, lim, x, k, pdf;
    bit            neg;
    rsl_pkg::hit_t h;
    o[0] = $signed(r.origin_x); o[1] = $signed(r.origin_y); o[2] = $signed(r.origin_z);
    d[0] = $signed(r.dir_x);    d[1] = $signed(r.dir_y);    d[2] = $signed(r.dir_z);
    a = '0; b = '0; p = '0;
    for (int i = 0; i < 3; i++) begin
      v = o[i] - wide_t'($signed(sphere_center[i]));
      a = a + d[i] * d[i];
      b = b + v * d[i];
      p = p + v * v;
    end
    c    = p - ({224'd0, sphere_radius_sq} << 16);
    disc = b * b - a * c;
    h    = '0;
    if (a == 0 || c <= 0 || disc < 0) return h;
    s   = floor_sqrt(disc);
    n   = -b - s;
    neg = n < 0;
    num = ((neg ? -n : n) << 16) + (a >>> 1);
    q   = num / a;
    lim = neg ? (wide_t'(1) << 31) : (wide_t'(1) << 31) - 1;
    if (q > lim) q = lim;
    if (neg) q = -q;
    x   = (c << 64) / p;
    k   = floor_sqrt(x);
    pdf = (2 * ((wide_t'(1) << 32) - k) + 32768) >>> 16;
    h.hit           = 1'b1;
    h.near_distance = q[rsl_pkg::CW-1:0];
    h.inv_pdf       = pdf[rsl_pkg::IPW-1:0];
    return h;
  endfunction

  function automatic rsl_pkg::ray_t make_ray(input int ox, oy, oz, dx, dy, dz);
    rsl_pkg::ray_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x    = dx; r.dir_y    = dy; r.dir_z    = dz;
    return r;
  endfunction

  task automatic write_reg(input logic [rsl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rsl_pkg::CW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      rsl_pkg::REG_CENTER_X:  sphere_center[0] = val;
      rsl_pkg::REG_CENTER_Y:  sphere_center[1] = val;
      rsl_pkg::REG_CENTER_Z:  sphere_center[2] = val;
      rsl_pkg::REG_RADIUS_SQ: sphere_radius_sq = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_ray(input rsl_pkg::ray_t r, input bit is_miss);
    if (!quiet && $urandom_range(99) < 35) begin
      ray_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    ray_if.valid <= 1'b1;
    ray_if.data  <= r;
    do @(posedge clk_i); while (!ray_if.ready);
    pending_hits.push_back(is_miss ? rsl_pkg::hit_t'('0) : sphere_hit(r));
    rays_sent++;
  endtask

  function automatic rsl_pkg::ray_t random_ray();
    rsl_pkg::ray_t r;
    int            scale, off [3];
    if ($urandom_range(99) < 35) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      // aim roughly at the sphere center from a short distance
      scale = $urandom_range(14, 22);
      for (int i = 0; i < 3; i++)
        off[i] = $signed($urandom) >>> (31 - scale);
      r.origin_x = sphere_center[0] + off[0];
      r.origin_y = sphere_center[1] + off[1];
      r.origin_z = sphere_center[2] + off[2];
      r.dir_x = -off[0] + ($signed($urandom) >>> (31 - scale + 2));
      r.dir_y = -off[1] + ($signed($urandom) >>> (31 - scale + 2));
      r.dir_z = -off[2] + ($signed($urandom) >>> (31 - scale + 2));
      if ($urandom_range(9) == 0) begin
        r.dir_x = -r.dir_x; r.dir_y = -r.dir_y; r.dir_z = -r.dir_z;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    rsl_pkg::hit_t exp_hit;
    if (!rst_ni) begin
      hit_if.ready <= 1'b0;
    end else begin
      if (hit_if.valid && hit_if.ready) begin
        results_seen++;
        if (pending_hits.size() == 0) begin
          $error("result transfer with nothing pending");
          mismatches++;
        end else begin
          exp_hit = pending_hits.pop_front();
          if (exp_hit.hit) hits_seen++;
          if (hit_if.data.hit !== exp_hit.hit) begin
            $error("hit: expected %0d, got %0d", exp_hit.hit, hit_if.data.hit);
            mismatches++;
          end
          if (hit_if.data.near_distance !== exp_hit.near_distance) begin
            $error("near_distance: expected %0d, got %0d",
                   exp_hit.near_distance, hit_if.data.near_distance);
            mismatches++;
          end
          if (hit_if.data.inv_pdf !== exp_hit.inv_pdf) begin
            $error("inv_pdf: expected %0d, got %0d", exp_hit.inv_pdf, hit_if.data.inv_pdf);
            mismatches++;
          end
        end
      end
      hit_if.ready <= quiet || ($urandom_range(99) >= 35);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** ray_sphere_light_hit_pdf: FAILED **");
      $finish;
    end
  end

  initial begin
    ray_row_t rows [$];
    rst_ni        <= 1'b0;
    ray_if.valid  <= 1'b0;
    ray_if.data   <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.idx    <= '0;
    cfg_if.wdata  <= '0;
    sphere_center = '{default: '0};
    sphere_radius_sq = rsl_pkg::RADIUS_SQ_RST;

    rows.push_back('{make_ray(2 * ONE, 0, 0, 0, 0, 0), 1'b1});
    rows.push_back('{make_ray(0, 0, 0, ONE, 0, 0), 1'b1});
    rows.push_back('{make_ray(ONE, 0, 0, -ONE, 0, 0), 1'b1});
    rows.push_back('{make_ray(0, ONE / 2, 0, 0, 0, ONE), 1'b1});
    rows.push_back('{make_ray(2 * ONE, 5 * ONE, 0, -ONE, 0, 0), 1'b1});
    rows.push_back('{make_ray(2 * ONE, 0, 0, -ONE, 0, 0), 1'b0});
    rows.push_back('{make_ray(2 * ONE, 0, 0, ONE, 0, 0), 1'b0});
    rows.push_back('{make_ray(0, 0, -3 * ONE, 0, 0, 2 * ONE), 1'b0});
    rows.push_back('{make_ray(2 * ONE, ONE, 0, -ONE, 0, 0), 1'b0});
    rows.push_back('{make_ray(-3 * ONE, ONE / 2, ONE / 3, ONE, 0, 0), 1'b0});
    rows.push_back('{make_ray(32'h8000_0000, 0, 0, 1, 0, 0), 1'b0});
    rows.push_back('{make_ray(32'h7fff_ffff, 0, 0, -1, 0, 0), 1'b0});
    rows.push_back('{make_ray(0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0), 1'b0});
    rows.push_back('{make_ray(0, 0, 32'h7fff_ffff, 0, 0, 32'h8000_0000), 1'b0});
    rows.push_back('{make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0});
    rows.push_back('{make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0});
    rows.push_back('{make_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                              -1, -1, -1), 1'b0});
    rows.push_back('{make_ray(5 * ONE, 0, 0, -1, 0, 0), 1'b0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_ray(rows[i].ray, rows[i].is_miss);
    ray_if.valid <= 1'b0;
    drain();

    // zero radius, then ignored writes to two unused indices
    write_reg(rsl_pkg::REG_RADIUS_SQ, '0);
    write_reg(rsl_pkg::CFG_IDX_W'(rsl_pkg::REG_RADIUS_SQ + 1), 32'hdead_beef);
    write_reg(rsl_pkg::CFG_IDX_W'(8'hff), 32'h1234_5678);
    send_ray(make_ray(2 * ONE, 0, 0, -ONE, 0, 0), 1'b0);
    send_ray(make_ray(0, 0, 0, ONE, 0, 0), 1'b1);
    ray_if.valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(rsl_pkg::REG_RADIUS_SQ, rsl_pkg::RADIUS_SQ_RST);
        end
        1: begin
          write_reg(rsl_pkg::REG_CENTER_X, 32'h7fff_ffff);
          write_reg(rsl_pkg::REG_CENTER_Y, 32'h8000_0000);
          write_reg(rsl_pkg::REG_CENTER_Z, 32'h7fff_ffff);
          write_reg(rsl_pkg::REG_RADIUS_SQ, 32'hffff_ffff);
        end
        2: begin
          write_reg(rsl_pkg::REG_CENTER_X, 32'h8000_0000);
          write_reg(rsl_pkg::REG_CENTER_Y, 32'h7fff_ffff);
          write_reg(rsl_pkg::REG_CENTER_Z, 32'h8000_0000);
          write_reg(rsl_pkg::REG_RADIUS_SQ, '0);
        end
        default: begin
          write_reg(rsl_pkg::REG_CENTER_X, $signed($urandom) >>> $urandom_range(0, 16));
          write_reg(rsl_pkg::REG_CENTER_Y, $signed($urandom) >>> $urandom_range(0, 16));
          write_reg(rsl_pkg::REG_CENTER_Z, $signed($urandom) >>> $urandom_range(0, 16));
          write_reg(rsl_pkg::REG_RADIUS_SQ,
                    (phase == 6) ? $urandom : $urandom >> $urandom_range(0, 24));
        end
      endcase
      quiet = (phase == 3);
      repeat (245) send_ray(random_ray(), 1'b0);
      ray_if.valid <= 1'b0;
      quiet = 1'b0;
      drain();
    end

    $display("Covered %0d rays over 9 sphere settings; %0d results, %0d hits.",
             rays_sent, results_seen, hits_seen);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("** ray_sphere_light_hit_pdf: PASSED **");
    end else begin
      $display("** ray_sphere_light_hit_pdf: FAILED **");
    end
    $finish;
  end

endmodule
